[hdl/spaa_pkg.sv]
package spaa_pkg;

    // Rotation CORDIC step count (valid range 12 to 32).
    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_CNT_W      = $clog2(CORDIC_ITERATIONS + 1);

    // CORDIC datapath widths.
    localparam int ANG_W = 36;
    localparam int XY_W  = 40;

    // Q30 angle constants.
    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 40'sd652032874;

    // Fixed-point constants of the geometry.
    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [63:0] EPS_EARTH   = 64'sd7188036;
    localparam logic signed [63:0] EPS_TROPO   = 64'sd9846229;
    localparam logic [63:0]        R_EARTH_NUM = 64'd1627328592 << 30;
    localparam logic [63:0]        R_TROPO_NUM = 64'd1629376592 << 30;
    localparam logic [21:0]        ZERO_ANGLE_SUB = 22'd104858;
    localparam logic signed [63:0] TROPO_MAX   = 64'sd16777215;
    localparam logic signed [63:0] HALF_MAX    = 64'sd33554431;

    // Arctangent of 2^-k in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd31: v = 30'd0;
            default: v = 30'd1 << (5'd30 - k);
        endcase
        return v;
    endfunction

endpackage

[hdl/spaa_cordic.sv]
module spaa_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [spaa_pkg::ANG_W-1:0] i_angle,
    output logic                           o_done,
    output logic signed [spaa_pkg::XY_W-1:0]  o_sin,
    output logic signed [spaa_pkg::XY_W-1:0]  o_cos
);
    import spaa_pkg::*;

    logic                    r_busy;
    logic [CORDIC_CNT_W-1:0] r_cnt;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [ANG_W-1:0] r_z;
    logic                    r_neg;
    logic [4:0]              k;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ANG_W-1:0] da;

    assign k  = 5'(r_cnt);
    assign dx = r_y >>> k;
    assign dy = r_x >>> k;
    assign da = ANG_W'($signed({1'b0, atan_q30(k)}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                // Fold the angle into the right half plane; cosine is negated.
                if (i_angle > ANG_HALF_PI) begin
                    r_z   <= ANG_PI - i_angle;
                    r_neg <= 1'b1;
                end else if (i_angle < -ANG_HALF_PI) begin
                    r_z   <= -ANG_PI - i_angle;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= i_angle;
                    r_neg <= 1'b0;
                end
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == CORDIC_CNT_W'(CORDIC_ITERATIONS)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_sin  <= r_y;
                    o_cos  <= r_neg ? -r_x : r_x;
                end else begin
                    if (!r_z[ANG_W-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - da;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + da;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

[hdl/spaa_mul.sv]
module spaa_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod
);
    import spaa_pkg::*;

    logic        r_busy;
    logic        r_neg;
    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic [63:0] r_acc;

    // Shift-and-add over the magnitudes; the sign is applied at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mb == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_prod <= r_neg ? -$signed(r_acc) : $signed(r_acc);
                end else begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= {r_ma[62:0], 1'b0};
                    r_mb <= {1'b0, r_mb[63:1]};
                end
            end
        end
    end

endmodule

[hdl/spaa_div.sv]
module spaa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import spaa_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic [64:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[63:0], r_q[63]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 7'd64) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_quot <= r_q;
                end else begin
                    r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_q   <= {r_q[62:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

[hdl/spaa_isqrt.sv]
module spaa_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    import spaa_pkg::*;

    logic        r_busy;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    // Digit-by-digit square root, two radicand bits per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= 64'd1 << 62;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_root <= r_r[31:0];
                end else begin
                    if (r_v >= trial) begin
                        r_v <= r_v - trial;
                        r_r <= {1'b0, r_r[63:1]} + r_bit;
                    end else begin
                        r_r <= {1'b0, r_r[63:1]};
                    end
                    r_bit <= {2'b00, r_bit[63:2]};
                end
            end
        end
    end

endmodule

[hdl/sun_path_atmosphere_altitude_top.sv]
// Each of the 24 program steps runs its unit's iterations and then hands the result back:
// fourteen products at one iteration per significant bit of the second operand,
// three 64-step divides, five 32-step square roots and two 24-step CORDIC runs.
// The block takes one item at a time.
// An item whose sun angle matches the previous one is accepted and produces no result.
// Reset (synchronous, active low) empties the output and forgets the last angle.
module sun_path_atmosphere_altitude_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [21:0] i_latitude,
    input  logic [26:0] i_altitude,
    input  logic [21:0] i_sun_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_tropo_top_altitude,
    output logic [24:0] o_half_path_altitude
);
    import spaa_pkg::*;

    // The sequencer: each program step launches one shared unit, waits for its
    // done pulse and then writes the result back to the working registers.
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_FIN} t_state;
    typedef enum logic [4:0] {
        P_COS_LAT, P_C2, P_D_E, P_SQ_E, P_DIV_E, P_D_T, P_SQ_T, P_DIV_T,
        P_COS_SUN, P_MAG, P_Q, P_SB2, P_CB, P_CCB, P_SSB, P_DIF2, P_PCA,
        P_RTU, P_D, P_DD, P_RTRT, P_DCB, P_TERM, P_H
    } t_step;

    t_state r_state;
    t_step  r_pc;
    logic   r_last_valid;
    logic [21:0] r_last_sa;

    logic signed [21:0] r_lat;
    logic signed [26:0] r_alt;
    logic [21:0]        r_sa;

    // Working registers (Q30 values or lengths in 1/256 m).
    logic signed [63:0] r_c2, r_t, r_u, r_re, r_rt, r_pr;
    logic signed [63:0] r_s, r_c, r_sb, r_cb, r_ca, r_d;

    logic [23:0] r_tropo;
    logic [24:0] r_half;
    logic        r_out_valid;

    // Shared unit hook-up.
    logic                     cor_start, mul_start, div_start, sq_start;
    logic signed [ANG_W-1:0]  cor_angle;
    logic signed [63:0]       mul_a, mul_b;
    logic [63:0]              div_n, div_d, sq_v;
    logic                     cor_done, mul_done, div_done, sq_done, any_done;
    logic signed [XY_W-1:0]   cor_sin, cor_cos;
    logic signed [63:0]       mul_p;
    logic [63:0]              div_q;
    logic [31:0]              sq_root;

    logic               in_acc;
    logic               go;
    logic signed [63:0] dif;
    logic signed [63:0] root;
    logic signed [63:0] ssb_sum;
    logic signed [63:0] ssb_sh;
    logic signed [63:0] pr_sum;
    logic signed [63:0] tropo_d;

    assign o_in_ready  = r_state == ST_IDLE;
    assign in_acc      = i_in_valid && o_in_ready;
    assign go          = r_state == ST_RUN;
    assign any_done    = cor_done | mul_done | div_done | sq_done;
    assign root        = 64'($unsigned(sq_root));
    assign dif         = (r_pr > r_rt) ? r_pr - r_rt : r_rt - r_pr;
    assign ssb_sum     = r_t + mul_p;
    assign ssb_sh      = ssb_sum >>> 30;
    assign pr_sum      = r_re + 64'(r_alt);
    assign tropo_d     = r_rt - r_re;

    assign o_out_valid          = r_out_valid;
    assign o_tropo_top_altitude = r_tropo;
    assign o_half_path_altitude = r_half;

    // Operand selection for the current program step.
    always_comb begin
        cor_start = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        cor_angle = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_n     = '0;
        div_d     = '0;
        sq_v      = '0;
        unique case (r_pc)
            P_COS_LAT: begin
                cor_start = go;
                cor_angle = {{4{r_lat[21]}}, r_lat, 10'b0};
            end
            P_C2: begin
                mul_start = go;
                mul_a = r_c;
                mul_b = r_c;
            end
            P_D_E: begin
                mul_start = go;
                mul_a = EPS_EARTH;
                mul_b = r_c2;
            end
            P_D_T: begin
                mul_start = go;
                mul_a = EPS_TROPO;
                mul_b = r_c2;
            end
            P_SQ_E, P_SQ_T, P_CB: begin
                sq_start = go;
                sq_v = 64'(r_t) << 30;
            end
            P_DIV_E: begin
                div_start = go;
                div_n = R_EARTH_NUM;
                div_d = r_t;
            end
            P_DIV_T: begin
                div_start = go;
                div_n = R_TROPO_NUM;
                div_d = r_t;
            end
            P_COS_SUN: begin
                cor_start = go;
                cor_angle = {4'b0, r_sa, 10'b0};
            end
            P_MAG: begin
                mul_start = go;
                mul_a = r_pr;
                mul_b = r_s[63] ? -r_s : r_s;
            end
            P_Q: begin
                div_start = go;
                div_n = r_t;
                div_d = r_rt;
            end
            P_SB2: begin
                mul_start = go;
                mul_a = r_sb;
                mul_b = r_sb;
            end
            P_CCB: begin
                mul_start = go;
                mul_a = r_c;
                mul_b = r_cb;
            end
            P_SSB: begin
                mul_start = go;
                mul_a = r_s;
                mul_b = r_sb;
            end
            P_DIF2: begin
                mul_start = go;
                mul_a = dif;
                mul_b = dif;
            end
            P_PCA: begin
                mul_start = go;
                mul_a = r_pr;
                mul_b = ONE_Q30 - r_ca;
            end
            P_RTU: begin
                mul_start = go;
                mul_a = r_rt <<< 1;
                mul_b = r_u;
            end
            P_D, P_H: begin
                sq_start = go;
                sq_v = r_t;
            end
            P_DD: begin
                mul_start = go;
                mul_a = r_d;
                mul_b = r_d;
            end
            P_RTRT: begin
                mul_start = go;
                mul_a = r_rt;
                mul_b = r_rt;
            end
            P_DCB: begin
                mul_start = go;
                mul_a = r_d;
                mul_b = r_cb;
            end
            P_TERM: begin
                mul_start = go;
                mul_a = r_rt;
                mul_b = r_u;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pc         <= P_COS_LAT;
            r_last_valid <= 1'b0;
            r_last_sa    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // In the final state the output register is handled there alone.
            if (r_out_valid && i_out_ready && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    // An unchanged sun angle produces nothing.
                    if (in_acc && !(r_last_valid && i_sun_angle == r_last_sa)) begin
                        r_last_valid <= 1'b1;
                        r_last_sa    <= i_sun_angle;
                        r_lat        <= $signed(i_latitude);
                        r_alt        <= $signed(i_altitude);
                        r_sa         <= (i_sun_angle == '0) ? ZERO_ANGLE_SUB : i_sun_angle;
                        r_pc         <= P_COS_LAT;
                        r_state      <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (any_done) begin
                        unique case (r_pc)
                            P_COS_LAT: r_c <= 64'(cor_cos);
                            P_C2:      r_c2 <= mul_p >>> 30;
                            P_D_E, P_D_T: r_t <= ONE_Q30 - (mul_p >>> 30);
                            P_SQ_E, P_SQ_T: r_t <= (root == '0) ? 64'sd1 : root;
                            P_DIV_E:   r_re <= $signed(div_q);
                            P_DIV_T: begin
                                r_rt <= $signed(div_q);
                                r_pr <= pr_sum[63] ? '0 : pr_sum;
                            end
                            P_COS_SUN: begin
                                r_s <= 64'(cor_sin);
                                r_c <= 64'(cor_cos);
                            end
                            P_MAG:     r_t <= mul_p;
                            P_Q: begin
                                if (div_q > 64'(ONE_Q30)) begin
                                    r_sb <= r_s[63] ? -ONE_Q30 : ONE_Q30;
                                end else begin
                                    r_sb <= r_s[63] ? -$signed(div_q) : $signed(div_q);
                                end
                            end
                            P_SB2:     r_t <= ONE_Q30 - (mul_p >> 30);
                            P_CB:      r_cb <= root;
                            P_CCB:     r_t <= mul_p;
                            P_SSB: begin
                                if (ssb_sh > ONE_Q30) begin
                                    r_ca <= ONE_Q30;
                                end else if (ssb_sh < -ONE_Q30) begin
                                    r_ca <= -ONE_Q30;
                                end else begin
                                    r_ca <= ssb_sh;
                                end
                            end
                            P_DIF2:    r_t <= mul_p;
                            P_PCA:     r_u <= mul_p >> 30;
                            P_RTU:     r_t <= r_t + mul_p;
                            P_D:       r_d <= root;
                            P_DD:      r_t <= mul_p >> 2;
                            P_RTRT:    r_t <= r_t + mul_p;
                            P_DCB:     r_u <= mul_p >> 30;
                            // A negative radicand counts as zero.
                            P_TERM:    r_t <= ($unsigned(mul_p) > $unsigned(r_t)) ?
                                              '0 : r_t - mul_p;
                            P_H:       r_u <= root - r_re;
                        endcase
                        if (r_pc == P_H) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_pc    <= t_step'(r_pc + 1'b1);
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_FIN: begin
                    // Wait for the output register to be free, then saturate.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        if (tropo_d[63]) begin
                            r_tropo <= '0;
                        end else if (tropo_d > TROPO_MAX) begin
                            r_tropo <= '1;
                        end else begin
                            r_tropo <= tropo_d[23:0];
                        end
                        if (r_u[63]) begin
                            r_half <= '0;
                        end else if (r_u > HALF_MAX) begin
                            r_half <= '1;
                        end else begin
                            r_half <= r_u[24:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    spaa_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    spaa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    spaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    spaa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_v),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

endmodule

[hdl/spaa_checker.sv]
module spaa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [21:0] i_latitude,
    input logic [26:0] i_altitude,
    input logic [21:0] i_sun_angle,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_tropo_top_altitude,
    input logic [24:0] o_half_path_altitude
);

    // A reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tropo_top_altitude)
            && $stable(o_half_path_altitude))
        else $error("stalled result changed");

    // An offered result carries known values.
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_tropo_top_altitude, o_half_path_altitude}))
        else $error("result carries unknown bits");

    // The block is ready for an item straight after reset.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

endmodule

bind sun_path_atmosphere_altitude_top spaa_checker u_spaa_checker (.*);
